// ===== hdl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg: shared definitions for the sphere frustum cull core
// Widths, register codes, verdict codes and the structures that pass
// between the configuration, transform and classify stages.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int FIELD_WIDTH     = 16;
    localparam int MAX_WIDTH       = (COORD_WIDTH > FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
    localparam int VEC_WIDTH       = MAX_WIDTH + 1;
    localparam int PROD_WIDTH      = VEC_WIDTH + FIELD_WIDTH;
    localparam int SUM_WIDTH       = PROD_WIDTH + 3;
    localparam int RF_WIDTH        = COORD_WIDTH + FIELD_WIDTH;
    localparam int BOUND_WIDTH     = MAX_WIDTH + 2;
    localparam int DEPTH_SHIFT     = 14;
    localparam int LAT_SHIFT       = 12;
    localparam int AZ_TRUNC_WIDTH  = BOUND_WIDTH + DEPTH_SHIFT;
    localparam int ZPROD_WIDTH     = AZ_TRUNC_WIDTH + FIELD_WIDTH + 1;
    localparam int LAT_WIDTH       = ZPROD_WIDTH + 3;

    localparam int NUM_AXES        = 3;
    localparam int IN_FIELDS       = 4;
    localparam int IN_TDATA_WIDTH  = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int VERDICT_WIDTH   = 2;
    localparam int OUT_TDATA_WIDTH = 8;

    localparam int VEC_REG_WIDTH   = 48;
    localparam int PAIR_REG_WIDTH  = 32;
    localparam int CFG_DATA_WIDTH  = VEC_REG_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_CAMERA_POSITION,
        REG_AXIS_RIGHT,
        REG_AXIS_UP,
        REG_AXIS_BACK,
        REG_NEAR_FAR,
        REG_SLOPES,
        REG_SPHERE_FACTORS
    } cfg_reg_t;

    typedef enum logic [VERDICT_WIDTH-1:0] {
        VERDICT_OUTSIDE,
        VERDICT_INTERSECT,
        VERDICT_INSIDE
    } verdict_t;

    typedef struct packed {
        logic [VEC_REG_WIDTH-1:0]  camera;
        logic [VEC_REG_WIDTH-1:0]  right;
        logic [VEC_REG_WIDTH-1:0]  up;
        logic [VEC_REG_WIDTH-1:0]  back;
        logic [PAIR_REG_WIDTH-1:0] near_far;
        logic [PAIR_REG_WIDTH-1:0] slopes;
        logic [PAIR_REG_WIDTH-1:0] factors;
    } cfg_t;

    typedef struct packed {
        logic signed [SUM_WIDTH-1:0] ax;
        logic signed [SUM_WIDTH-1:0] ay;
        logic signed [SUM_WIDTH-1:0] az;
        logic [COORD_WIDTH-1:0]      radius;
        logic [RF_WIDTH-1:0]         rf_h;
        logic [RF_WIDTH-1:0]         rf_v;
    } xf_t;

endpackage

// ===== hdl/sphere_frustum_cull_core.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_cull_core: bounding sphere versus view frustum classifier
// Each item is a sphere; each result is OUTSIDE, INTERSECT or INSIDE.
// ----------------------------------------------------------------------------
// The core accepts one sphere item per clock cycle while input ready is high
// and returns its verdict through the register stages camera offset, axis
// products, dot-product sums, depth tests with slope scaling, and lateral
// tests. Every stage has its own valid bit and holds while full and the next
// stage holds, so a stalled output fills bubbles before input ready drops.
// Configuration registers are read directly by the stages and may only be
// written while no item is in flight.
module sphere_frustum_cull_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sfc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // center_x, center_y, center_z, radius
    input  logic [sfc_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // verdict, then zero padding
    output logic [sfc_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    sfc_pkg::cfg_t     cfg;
    sfc_pkg::xf_t      xf;
    logic              xf_valid;
    logic              xf_ready;
    sfc_pkg::verdict_t verdict;

    sfc_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    sfc_transform u_transform
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .out_xf    (xf)
    );

    sfc_classify u_classify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (xf_valid),
        .in_ready    (xf_ready),
        .in_xf       (xf),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (verdict)
    );

    assign m_axis_tdata = sfc_pkg::OUT_TDATA_WIDTH'(verdict);

endmodule

// ===== hdl/sfc_cfg.sv =====
// ----------------------------------------------------------------------------
// sfc_cfg: configuration register file
// Holds the camera position, axes, depth planes, slopes and sphere factors.
// ----------------------------------------------------------------------------
module sfc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sfc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sfc_pkg::CFG_DATA_WIDTH-1:0]  cfg_wr_data,
    output sfc_pkg::cfg_t                       cfg
);

    localparam int PW = sfc_pkg::PAIR_REG_WIDTH;

    sfc_pkg::cfg_t cfg_reg;
    sfc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (sfc_pkg::cfg_reg_t'(cfg_index))
                sfc_pkg::REG_CAMERA_POSITION: cfg_next.camera   = cfg_wr_data;
                sfc_pkg::REG_AXIS_RIGHT:      cfg_next.right    = cfg_wr_data;
                sfc_pkg::REG_AXIS_UP:         cfg_next.up       = cfg_wr_data;
                sfc_pkg::REG_AXIS_BACK:       cfg_next.back     = cfg_wr_data;
                sfc_pkg::REG_NEAR_FAR:        cfg_next.near_far = cfg_wr_data[PW-1:0];
                sfc_pkg::REG_SLOPES:          cfg_next.slopes   = cfg_wr_data[PW-1:0];
                sfc_pkg::REG_SPHERE_FACTORS:  cfg_next.factors  = cfg_wr_data[PW-1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/sfc_transform.sv =====
// ----------------------------------------------------------------------------
// sfc_transform: view-space transform pipeline
// Stage 1 subtracts the camera position, stage 2 forms the axis products and
// the radius-factor products, stage 3 sums them into ax, ay and depth az.
// ----------------------------------------------------------------------------
module sfc_transform
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  sfc_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [sfc_pkg::IN_TDATA_WIDTH-1:0] in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sfc_pkg::xf_t                       out_xf
);

    localparam int CW = sfc_pkg::COORD_WIDTH;
    localparam int FW = sfc_pkg::FIELD_WIDTH;
    localparam int VW = sfc_pkg::VEC_WIDTH;
    localparam int PW = sfc_pkg::PROD_WIDTH;
    localparam int SW = sfc_pkg::SUM_WIDTH;
    localparam int RW = sfc_pkg::RF_WIDTH;
    localparam int NA = sfc_pkg::NUM_AXES;

    logic en1, en2, en3;
    logic valid1_reg, valid2_reg, valid3_reg;

    logic signed [VW-1:0] vec_next [NA];
    logic signed [VW-1:0] vec_reg  [NA];
    logic [CW-1:0]        rad1_reg;

    logic [sfc_pkg::VEC_REG_WIDTH-1:0] axis_word [NA];
    logic signed [PW-1:0] prod_next [NA][NA];
    logic signed [PW-1:0] prod_reg  [NA][NA];
    logic [RW-1:0]        rf_h_next, rf_v_next;
    logic [RW-1:0]        rf_h_reg, rf_v_reg;
    logic [CW-1:0]        rad2_reg;

    sfc_pkg::xf_t xf_next;
    sfc_pkg::xf_t xf_reg;

    assign en3      = !valid3_reg || out_ready;
    assign en2      = !valid2_reg || en3;
    assign en1      = !valid1_reg || en2;
    assign in_ready = en1;

    assign axis_word[0] = cfg.right;
    assign axis_word[1] = cfg.up;
    assign axis_word[2] = cfg.back;

    always_comb
    begin
        for (int k = 0; k < NA; k++)
        begin
            vec_next[k] = VW'($signed(in_data[CW*k +: CW]))
                        - VW'($signed(cfg.camera[FW*k +: FW]));
        end
    end

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            for (int k = 0; k < NA; k++)
            begin
                prod_next[a][k] = PW'(vec_reg[k]) * PW'($signed(axis_word[a][FW*k +: FW]));
            end
        end
        rf_h_next = RW'(rad1_reg) * RW'(cfg.factors[2*FW-1:FW]);
        rf_v_next = RW'(rad1_reg) * RW'(cfg.factors[FW-1:0]);
    end

    always_comb
    begin
        xf_next.ax = SW'(prod_reg[0][0]) + SW'(prod_reg[0][1]) + SW'(prod_reg[0][2]);
        xf_next.ay = SW'(prod_reg[1][0]) + SW'(prod_reg[1][1]) + SW'(prod_reg[1][2]);
        xf_next.az = -(SW'(prod_reg[2][0]) + SW'(prod_reg[2][1]) + SW'(prod_reg[2][2]));
        xf_next.radius = rad2_reg;
        xf_next.rf_h   = rf_h_reg;
        xf_next.rf_v   = rf_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                valid1_reg <= in_valid;
            end
            if (en2)
            begin
                valid2_reg <= valid1_reg;
            end
            if (en3)
            begin
                valid3_reg <= valid2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            vec_reg  <= vec_next;
            rad1_reg <= in_data[CW*NA +: CW];
        end
        if (en2)
        begin
            prod_reg <= prod_next;
            rf_h_reg <= rf_h_next;
            rf_v_reg <= rf_v_next;
            rad2_reg <= rad1_reg;
        end
        if (en3)
        begin
            xf_reg <= xf_next;
        end
    end

    assign out_valid = valid3_reg;
    assign out_xf    = xf_reg;

endmodule

// ===== hdl/sfc_classify.sv =====
// ----------------------------------------------------------------------------
// sfc_classify: depth and lateral plane tests
// Stage 4 runs the depth tests and scales depth by the slopes, stage 5 runs
// the lateral tests and picks the verdict in the fixed check order.
// ----------------------------------------------------------------------------
module sfc_classify
(
    input  logic                clk,
    input  logic                rst_n,
    input  sfc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  sfc_pkg::xf_t        in_xf,
    output logic                out_valid,
    input  logic                out_ready,
    output sfc_pkg::verdict_t   out_verdict
);

    localparam int FW  = sfc_pkg::FIELD_WIDTH;
    localparam int SW  = sfc_pkg::SUM_WIDTH;
    localparam int BW  = sfc_pkg::BOUND_WIDTH;
    localparam int AZW = sfc_pkg::AZ_TRUNC_WIDTH;
    localparam int ZW  = sfc_pkg::ZPROD_WIDTH;
    localparam int LW  = sfc_pkg::LAT_WIDTH;
    localparam int DS  = sfc_pkg::DEPTH_SHIFT;
    localparam int LS  = sfc_pkg::LAT_SHIFT;

    logic en4, en5;
    logic valid4_reg, valid5_reg;

    logic signed [BW-1:0]  far_p_r, far_m_r, near_p_r, near_m_r;
    logic signed [SW-1:0]  far_p_q, far_m_q, near_p_q, near_m_q;
    logic signed [AZW-1:0] az_trunc;

    logic                 depth_out_next, depth_int_next;
    logic                 depth_out_reg, depth_int_reg;
    logic signed [ZW-1:0] z_h_next, z_v_next, z_h_reg, z_v_reg;
    logic signed [LW-1:0] a_h_next, a_v_next, a_h_reg, a_v_reg;
    logic signed [LW-1:0] d_h_next, d_v_next, d_h_reg, d_v_reg;

    logic signed [LW-1:0] p_h, m_h, p_v, m_v;
    logic                 out_h, out_v, int_h, int_v;

    sfc_pkg::verdict_t verdict_next;
    sfc_pkg::verdict_t verdict_reg;

    assign en5      = !valid5_reg || out_ready;
    assign en4      = !valid4_reg || en5;
    assign in_ready = en4;

    always_comb
    begin
        far_p_r  = $signed(BW'(cfg.near_far[2*FW-1:FW])) + $signed(BW'(in_xf.radius));
        far_m_r  = $signed(BW'(cfg.near_far[2*FW-1:FW])) - $signed(BW'(in_xf.radius));
        near_p_r = $signed(BW'(cfg.near_far[FW-1:0])) + $signed(BW'(in_xf.radius));
        near_m_r = $signed(BW'(cfg.near_far[FW-1:0])) - $signed(BW'(in_xf.radius));
        far_p_q  = SW'(far_p_r) <<< DS;
        far_m_q  = SW'(far_m_r) <<< DS;
        near_p_q = SW'(near_p_r) <<< DS;
        near_m_q = SW'(near_m_r) <<< DS;

        depth_out_next = ($signed(in_xf.az) > far_p_q) || ($signed(in_xf.az) < near_m_q);
        depth_int_next = ($signed(in_xf.az) > far_m_q) || ($signed(in_xf.az) < near_p_q);

        // Depth is bounded whenever the depth test passes, so the narrowed
        // depth is exact in every case where the lateral tests count.
        az_trunc = $signed(in_xf.az[AZW-1:0]);
        z_h_next = ZW'(az_trunc) * ZW'($signed({1'b0, cfg.slopes[2*FW-1:FW]}));
        z_v_next = ZW'(az_trunc) * ZW'($signed({1'b0, cfg.slopes[FW-1:0]}));

        a_h_next = LW'($signed(in_xf.ax)) <<< LS;
        a_v_next = LW'($signed(in_xf.ay)) <<< LS;
        d_h_next = $signed(LW'(in_xf.rf_h)) <<< DS;
        d_v_next = $signed(LW'(in_xf.rf_v)) <<< DS;
    end

    always_comb
    begin
        p_h = a_h_reg - LW'(z_h_reg);
        m_h = a_h_reg + LW'(z_h_reg);
        p_v = a_v_reg - LW'(z_v_reg);
        m_v = a_v_reg + LW'(z_v_reg);

        out_h = (p_h > d_h_reg) || (-m_h > d_h_reg);
        out_v = (p_v > d_v_reg) || (-m_v > d_v_reg);
        int_h = (p_h > -d_h_reg) || (m_h < d_h_reg);
        int_v = (p_v > -d_v_reg) || (m_v < d_v_reg);

        if (depth_out_reg || out_h || out_v)
        begin
            verdict_next = sfc_pkg::VERDICT_OUTSIDE;
        end
        else if (depth_int_reg || int_v || int_h)
        begin
            verdict_next = sfc_pkg::VERDICT_INTERSECT;
        end
        else
        begin
            verdict_next = sfc_pkg::VERDICT_INSIDE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else
        begin
            if (en4)
            begin
                valid4_reg <= in_valid;
            end
            if (en5)
            begin
                valid5_reg <= valid4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            depth_out_reg <= depth_out_next;
            depth_int_reg <= depth_int_next;
            z_h_reg       <= z_h_next;
            z_v_reg       <= z_v_next;
            a_h_reg       <= a_h_next;
            a_v_reg       <= a_v_next;
            d_h_reg       <= d_h_next;
            d_v_reg       <= d_v_next;
        end
        if (en5)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid   = valid5_reg;
    assign out_verdict = verdict_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for sphere_frustum_cull_core
// Loads several camera and frustum settings through the register port, from
// the reset values and realistic views to degenerate and extreme ones. Under
// each setting it streams bounding-sphere items, most of them placed around
// the frustum so that every verdict and every bound is reached, and compares
// each verdict with the one worked out by an exact 64-bit integer classifier
// kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] UNMAPPED_REG = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AFTER  = 60;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // center_x, center_y, center_z, radius
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // verdict, then zero padding
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

    logic [63:0]               frustum_regs [7];
    logic [IN_TDATA_WIDTH-1:0] sphere_queue [$];
    verdict_t                  verdict_queue [$];

    int       send_idle_pct = 33;
    int       recv_idle_pct = 52;
    int       mismatches = 0;
    int       verdicts_seen = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       stall_cycles = 0;
    verdict_t want_verdict;
    logic [VERDICT_WIDTH-1:0] got_verdict;

    sphere_frustum_cull_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint sfield(input logic [63:0] word, input int k);
        logic signed [15:0] f;
        f = word[16*k +: 16];
        return f;
    endfunction

    function automatic longint ufield(input logic [63:0] word, input int k);
        return longint'(word[16*k +: 16]);
    endfunction

    function automatic longint axis_dot(input longint vx, input longint vy, input longint vz,
                                        input logic [63:0] axis);
        return vx * sfield(axis, 0) + vy * sfield(axis, 1) + vz * sfield(axis, 2);
    endfunction

    function automatic verdict_t classify_sphere(input logic [IN_TDATA_WIDTH-1:0] sphere);
        longint vx, vy, vz, az, ax, ay, r, near_q, far_q;
        longint a1, a2, z1, z2, d1, d2;
        vx = sfield(sphere, 0) - sfield(frustum_regs[REG_CAMERA_POSITION], 0);
        vy = sfield(sphere, 1) - sfield(frustum_regs[REG_CAMERA_POSITION], 1);
        vz = sfield(sphere, 2) - sfield(frustum_regs[REG_CAMERA_POSITION], 2);
        az = -axis_dot(vx, vy, vz, frustum_regs[REG_AXIS_BACK]);
        ax = axis_dot(vx, vy, vz, frustum_regs[REG_AXIS_RIGHT]);
        ay = axis_dot(vx, vy, vz, frustum_regs[REG_AXIS_UP]);
        near_q = ufield(frustum_regs[REG_NEAR_FAR], 0) * 16384;
        far_q = ufield(frustum_regs[REG_NEAR_FAR], 1) * 16384;
        r = ufield(sphere, 3) * 16384;
        if (az > far_q + r || az < near_q - r)
            return VERDICT_OUTSIDE;
        a1 = ax * 4096;
        a2 = ay * 4096;
        z1 = az * ufield(frustum_regs[REG_SLOPES], 1);
        z2 = az * ufield(frustum_regs[REG_SLOPES], 0);
        d1 = ufield(frustum_regs[REG_SPHERE_FACTORS], 1) * r;
        d2 = ufield(frustum_regs[REG_SPHERE_FACTORS], 0) * r;
        if (a1 - z1 > d1 || -(a1 + z1) > d1)
            return VERDICT_OUTSIDE;
        if (a2 - z2 > d2 || -(a2 + z2) > d2)
            return VERDICT_OUTSIDE;
        if (az > far_q - r || az < near_q + r)
            return VERDICT_INTERSECT;
        if (a2 - z2 > -d2 || a2 + z2 < d2)
            return VERDICT_INTERSECT;
        if (a1 - z1 > -d1 || a1 + z1 < d1)
            return VERDICT_INTERSECT;
        return VERDICT_INSIDE;
    endfunction

    // Places a sphere at the given depth and lateral offsets in camera space.
    function automatic logic [IN_TDATA_WIDTH-1:0] camera_sphere(input int depth, input int lat_x,
                                                                input int lat_y, input int rad);
        longint c [3];
        for (int k = 0; k < 3; k++)
        begin
            c[k] = sfield(frustum_regs[REG_CAMERA_POSITION], k)
                 + ((-sfield(frustum_regs[REG_AXIS_BACK], k) * longint'(depth)
                     + sfield(frustum_regs[REG_AXIS_RIGHT], k) * longint'(lat_x)
                     + sfield(frustum_regs[REG_AXIS_UP], k) * longint'(lat_y)) >>> 14);
        end
        return {rad[15:0], c[2][15:0], c[1][15:0], c[0][15:0]};
    endfunction

    task automatic queue_view_spheres(input int count);
        longint depth, rad, span_x, span_y, mag;
        int lat_x, lat_y;
        repeat (count)
        begin
            depth = longint'($urandom_range(0, 32'(ufield(frustum_regs[REG_NEAR_FAR], 1) + 400)))
                  - 200;
            rad = ($urandom_range(9) == 0) ? longint'($urandom_range(0, 65535))
                                           : longint'($urandom_range(0, 300));
            mag = (depth < 0) ? -depth : depth;
            span_x = (mag * ufield(frustum_regs[REG_SLOPES], 1)
                      + rad * ufield(frustum_regs[REG_SPHERE_FACTORS], 1)) / 4096 * 5 / 4 + 40;
            span_y = (mag * ufield(frustum_regs[REG_SLOPES], 0)
                      + rad * ufield(frustum_regs[REG_SPHERE_FACTORS], 0)) / 4096 * 5 / 4 + 40;
            lat_x = int'(longint'($urandom_range(0, int'(2 * span_x))) - span_x);
            lat_y = int'(longint'($urandom_range(0, int'(2 * span_y))) - span_y);
            sphere_queue.push_back(camera_sphere(int'(depth), lat_x, lat_y, int'(rad)));
        end
    endtask

    task automatic queue_raw_spheres(input int count);
        repeat (count)
        begin
            sphere_queue.push_back({$urandom, $urandom});
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        if (idx <= REG_SPHERE_FACTORS)
            frustum_regs[idx] = (idx >= REG_NEAR_FAR) ? {32'h0, value[31:0]} : {16'h0, value};
    endtask

    task automatic load_frustum(input logic [47:0] cam, input logic [47:0] right,
                                input logic [47:0] up, input logic [47:0] back,
                                input logic [47:0] near_far, input logic [47:0] slopes,
                                input logic [47:0] factors);
        write_reg(REG_CAMERA_POSITION, cam);
        write_reg(REG_AXIS_RIGHT, right);
        write_reg(REG_AXIS_UP, up);
        write_reg(REG_AXIS_BACK, back);
        write_reg(REG_NEAR_FAR, near_far);
        write_reg(REG_SLOPES, slopes);
        write_reg(REG_SPHERE_FACTORS, factors);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_for_idle();
        while (sphere_queue.size() != 0 || s_axis_tvalid || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Sphere source.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_queue.push_back(classify_sphere(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (sphere_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sphere_queue.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Verdict sink and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                verdicts_seen++;
                got_verdict = m_axis_tdata[VERDICT_WIDTH-1:0];
                if (verdict_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected verdict %0d with no sphere pending", got_verdict);
                end
                else
                begin
                    want_verdict = verdict_queue.pop_front();
                    if (got_verdict !== want_verdict)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Verdict mismatch at item %0d: expected %0d, got %0d",
                                     verdicts_seen, want_verdict, got_verdict);
                    end
                end
            end
            // One long back-pressure stretch so the pipeline fills and input ready drops.
            if (!hold_done && verdicts_seen == HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (sphere_queue.size() == 0 && !s_axis_tvalid && verdict_queue.size() == 0))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL sphere_frustum_cull_core");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 7; i++)
            frustum_regs[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: every register zero.
        sphere_queue.push_back(64'h0);
        sphere_queue.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        sphere_queue.push_back({16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF});
        wait_for_idle();

        // Camera looking down -z, with slopes that make exact bound hits reachable.
        load_frustum({16'd480, 16'hFEC0, 16'd160}, {16'd0, 16'd0, 16'd16384},
                     {16'd0, 16'd16384, 16'd0}, {16'd16384, 16'd0, 16'd0},
                     {16'd0, 16'd3200, 16'd16}, {16'd0, 16'd3072, 16'd2304},
                     {16'd0, 16'd5120, 16'd4699});
        sphere_queue.push_back(camera_sphere(800, 0, 0, 32));
        sphere_queue.push_back(camera_sphere(-800, 0, 0, 32));
        sphere_queue.push_back(camera_sphere(4000, 0, 0, 16));
        sphere_queue.push_back(camera_sphere(16, 0, 0, 64));
        sphere_queue.push_back(camera_sphere(3200, 0, 0, 64));
        sphere_queue.push_back(camera_sphere(3200, 0, 0, 0));
        sphere_queue.push_back(camera_sphere(16, 0, 0, 0));
        sphere_queue.push_back(camera_sphere(-48, 0, 0, 64));
        sphere_queue.push_back(camera_sphere(800, -2000, 0, 16));
        sphere_queue.push_back(camera_sphere(800, 2000, 0, 16));
        sphere_queue.push_back(camera_sphere(800, 0, 1500, 16));
        sphere_queue.push_back(camera_sphere(800, 0, -1500, 16));
        sphere_queue.push_back(camera_sphere(800, 600, 0, 50));
        sphere_queue.push_back(camera_sphere(800, 0, 450, 50));
        sphere_queue.push_back(camera_sphere(800, 0, 0, 65535));
        sphere_queue.push_back(camera_sphere(1024, 788, 0, 16));
        sphere_queue.push_back(camera_sphere(1024, -788, 0, 16));
        sphere_queue.push_back(camera_sphere(1024, 748, 0, 16));
        sphere_queue.push_back(camera_sphere(1024, 0, 576, 0));
        sphere_queue.push_back(camera_sphere(0, 0, 0, 0));
        sphere_queue.push_back({16'h0000, 16'h8000, 16'h8000, 16'h8000});
        sphere_queue.push_back({16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        queue_view_spheres(130);
        wait_for_idle();

        // Camera turned about the up axis, from a random position.
        if ($urandom_range(1) == 0)
            load_frustum({16'($urandom_range(0, 16000) - 8000), 16'($urandom_range(0, 16000) - 8000),
                          16'($urandom_range(0, 16000) - 8000)},
                         {-16'sd11585, 16'd0, 16'd11585}, {16'd0, 16'd16384, 16'd0},
                         {16'd11585, 16'd0, 16'd11585},
                         {16'd0, 16'd2000, 16'd8}, {16'd0, 16'd3072, 16'd2304},
                         {16'd0, 16'd5120, 16'd4699});
        else
            load_frustum({16'($urandom_range(0, 16000) - 8000), 16'($urandom_range(0, 16000) - 8000),
                          16'($urandom_range(0, 16000) - 8000)},
                         {-16'sd8192, 16'd0, 16'd14189}, {16'd0, 16'd16384, 16'd0},
                         {16'd14189, 16'd0, 16'd8192},
                         {16'd0, 16'd2000, 16'd8}, {16'd0, 16'd3072, 16'd2304},
                         {16'd0, 16'd5120, 16'd4699});
        queue_view_spheres(100);
        wait_for_idle();

        send_idle_pct <= 52;
        recv_idle_pct <= 33;

        // Extreme register contents.
        load_frustum({16'h8000, 16'h7FFF, 16'h8000}, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF,
                     {16'h0001, 16'h7FFF, 16'h8000}, 48'hFFFF_0000, 48'hFFFF_FFFF,
                     48'hFFFF_FFFF);
        queue_raw_spheres(40);
        wait_for_idle();

        // Degenerate frustum: zero right axis, near beyond far, zero slopes,
        // junk above the register width and a write to an unmapped index.
        write_reg(UNMAPPED_REG, 48'hFFFF_FFFF_FFFF);
        load_frustum(48'({$urandom, $urandom}), 48'h0, 48'({$urandom, $urandom}),
                     48'({$urandom, $urandom}),
                     48'hA5A5_0010_0200, 48'hFFFF_0000_0000, 48'h1234_0000_1000);
        queue_raw_spheres(40);
        wait_for_idle();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;

        // Camera at the origin with the farthest far plane.
        load_frustum(48'h0, {16'd0, 16'd0, 16'd16384}, {16'd0, 16'd16384, 16'd0},
                     {16'd16384, 16'd0, 16'd0}, {16'd0, 16'hFFFF, 16'd0},
                     {16'd0, 16'd4096, 16'd4096}, {16'd0, 16'd5793, 16'd5793});
        queue_view_spheres(100);
        wait_for_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS sphere_frustum_cull_core");
        else
            $display("FAIL sphere_frustum_cull_core");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sfc_pkg.sv
hdl/sfc_cfg.sv
hdl/sfc_transform.sv
hdl/sfc_classify.sv
hdl/sphere_frustum_cull_core.sv
tb/tb.sv
